// ===== rtl/fet_pkg.sv =====
// Shared types and constants for the free extent table.
package fet_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int START_W     = 32;
  localparam int LEN_W       = 34;
  localparam int SIZE_W      = 32;
  localparam int TOT_W       = 38;
  localparam int END_W       = LEN_W + 1;

  // operation kinds
  localparam logic [2:0] K_INSERT = 3'd0;
  localparam logic [2:0] K_REMOVE = 3'd1;
  localparam logic [2:0] K_DEFRAG = 3'd2;
  localparam logic [2:0] K_FIND   = 3'd3;
  localparam logic [2:0] K_POS    = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_BADPOS  = 3'd4;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } entry_t;

  // request to the shared adder
  typedef struct packed {
    logic [TOT_W-1:0] a;
    logic [TOT_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

// ===== rtl/fet_ram.sv =====
// Generic single-port-write, registered-read RAM.
module fet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fet_alu.sv =====
// Shared add/subtract unit for totals, extent ends and merged lengths.
module fet_alu (
  input  fet_pkg::alu_req_t             req,
  output logic [fet_pkg::TOT_W-1:0]     sum
);
  import fet_pkg::*;

  // subtract as add of the inverted operand plus one
  assign sum = req.a + (req.sub ? ~req.b : req.b) + TOT_W'(req.sub);

endmodule

// ===== rtl/free_extent_table.sv =====
// Top level of the free extent table: sequencer, table RAM and shared adder.
//
//  channel | signals                                            | role
//  in      | in_valid, in_ready, kind, start_addr, chunk_size,  | one operation per transfer
//          | insert_pos                                         |
//  out     | out_valid, out_ready, status, found_index, changed,| one result per operation
//          | entry_count, total_bytes                           |
//
// One operation at a time; in_ready is high only while the sequencer is idle.
// Insert shifts each entry up through a read and a move state; remove, find and
// insert position check scanned entries one at a time; defragment repeats merge
// passes until one merges nothing or one entry is left. The single table read port paces all of these.
// Reset clears count and total; table contents need no clearing.
// A finished result waits in the output register while a new operation starts.
module free_extent_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [31:0] start_addr,
  input  logic [31:0] chunk_size,
  input  logic signed [7:0] insert_pos,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [6:0]  found_index,
  output logic        changed,
  output logic [6:0]  entry_count,
  output logic [37:0] total_bytes
);
  import fet_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_MV  = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_SCAN_RD = 4'd4;
  localparam logic [3:0] S_SCAN_CK = 4'd5;
  localparam logic [3:0] S_RM_RD   = 4'd6;
  localparam logic [3:0] S_RM_MV   = 4'd7;
  localparam logic [3:0] S_DF_RA   = 4'd8;
  localparam logic [3:0] S_DF_A    = 4'd9;
  localparam logic [3:0] S_DF_B    = 4'd10;
  localparam logic [3:0] S_DF_M    = 4'd11;
  localparam logic [3:0] S_DF_W    = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0]         state, state_next;
  logic [2:0]         op, op_next;
  logic [START_W-1:0] addr, addr_next;
  logic [SIZE_W-1:0]  size, size_next;
  logic [CNT_W-1:0]   at, at_next;
  logic [CNT_W-1:0]   i, i_next;
  logic [CNT_W-1:0]   wr, wr_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [TOT_W-1:0]   total, total_next;
  logic [END_W-1:0]   best, best_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic [2:0]         st, st_next;
  logic               chg, chg_next;
  logic               pass_merged, pass_merged_next;
  entry_t             cur, cur_next;
  logic [LEN_W-1:0]   nlen, nlen_next;

  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  entry_t             wdata, rdata;
  logic [$bits(entry_t)-1:0] rdata_raw;
  alu_req_t           areq;
  logic [TOT_W-1:0]   asum;
  logic [END_W-1:0]   endv;
  logic               bad_pos;

  fet_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  fet_alu u_alu (.req(areq), .sum(asum));
  assign endv = asum[END_W-1:0];

  assign in_ready = (state == S_IDLE);
  assign bad_pos  = (insert_pos != -8'sd1) &&
                    (insert_pos[7] || (CNT_W'(insert_pos[6:0]) > cnt));

  // sequencer
  always_comb begin
    state_next       = state;
    op_next          = op;
    addr_next        = addr;
    size_next        = size;
    at_next          = at;
    i_next           = i;
    wr_next          = wr;
    cnt_next         = cnt;
    total_next       = total;
    best_next        = best;
    idx_next         = idx;
    st_next          = st;
    chg_next         = chg;
    pass_merged_next = pass_merged;
    cur_next         = cur;
    nlen_next        = nlen;
    we               = 1'b0;
    waddr            = i[IDX_W-1:0];
    wdata            = rdata;
    raddr            = i[IDX_W-1:0];
    areq.a           = TOT_W'(cur.start);
    areq.b           = TOT_W'(cur.len);
    areq.sub         = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next          = kind;
          addr_next        = start_addr;
          size_next        = chunk_size;
          st_next          = ST_OK;
          idx_next         = '0;
          chg_next         = 1'b0;
          i_next           = '0;
          wr_next          = '0;
          pass_merged_next = 1'b0;
          best_next        = END_W'(1);
          state_next       = S_DONE;
          case (kind)
            K_INSERT: begin
              if (chunk_size == '0 || start_addr == '0) begin
                st_next = ST_ZERO;
              end else if (cnt >= CNT_W'(MAX_ENTRIES)) begin
                st_next = ST_FULL;
              end else if (bad_pos) begin
                st_next = ST_BADPOS;
              end else begin
                at_next    = insert_pos[7] ? cnt : CNT_W'(insert_pos[6:0]);
                i_next     = cnt;
                state_next = (cnt > at_next) ? S_INS_RD : S_INS_WR;
              end
            end
            K_REMOVE, K_FIND: begin
              if (cnt == '0) st_next = ST_MISSING;
              else state_next = S_SCAN_RD;
            end
            K_POS: begin
              if (cnt != '0) state_next = S_SCAN_RD;
            end
            K_DEFRAG: begin
              if (cnt > CNT_W'(1)) state_next = S_DF_RA;
            end
            default: state_next = S_DONE;
          endcase
        end
      end

      // shift up one entry: read below, write here
      S_INS_RD: begin
        raddr      = IDX_W'(i - CNT_W'(1));
        state_next = S_INS_MV;
      end
      S_INS_MV: begin
        we         = 1'b1;
        i_next     = i - CNT_W'(1);
        state_next = (i_next > at) ? S_INS_RD : S_INS_WR;
      end
      S_INS_WR: begin
        we          = 1'b1;
        waddr       = at[IDX_W-1:0];
        wdata.start = addr;
        wdata.len   = LEN_W'(size);
        areq.a      = total;
        areq.b      = TOT_W'(size);
        total_next  = asum;
        cnt_next    = cnt + CNT_W'(1);
        state_next  = S_DONE;
      end

      // linear scan for remove, find and insert position
      S_SCAN_RD: begin
        state_next = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (op == K_POS) begin
          areq.a = TOT_W'(rdata.start);
          areq.b = TOT_W'(rdata.len);
          if (endv > best && endv <= END_W'(addr)) begin
            best_next = endv;
            idx_next  = i + CNT_W'(1);
          end
          i_next     = i + CNT_W'(1);
          state_next = (i_next < cnt) ? S_SCAN_RD : S_DONE;
        end else if (rdata.start == addr) begin
          idx_next = i;
          if (op == K_REMOVE) begin
            areq.a     = total;
            areq.b     = TOT_W'(rdata.len);
            areq.sub   = 1'b1;
            total_next = asum;
            cnt_next   = cnt - CNT_W'(1);
            state_next = (i < cnt_next) ? S_RM_RD : S_DONE;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          i_next = i + CNT_W'(1);
          if (i_next < cnt) begin
            state_next = S_SCAN_RD;
          end else begin
            st_next    = ST_MISSING;
            state_next = S_DONE;
          end
        end
      end

      // shift down one entry after a removal
      S_RM_RD: begin
        raddr      = IDX_W'(i + CNT_W'(1));
        state_next = S_RM_MV;
      end
      S_RM_MV: begin
        we         = 1'b1;
        i_next     = i + CNT_W'(1);
        state_next = (i_next < cnt) ? S_RM_RD : S_DONE;
      end

      // merge pass: read current, maybe next, then write back compacted
      S_DF_RA: begin
        state_next = S_DF_A;
      end
      S_DF_A: begin
        cur_next = rdata;
        if (i + CNT_W'(1) < cnt) begin
          raddr      = IDX_W'(i + CNT_W'(1));
          state_next = S_DF_B;
        end else begin
          i_next     = i + CNT_W'(1);
          state_next = S_DF_W;
        end
      end
      S_DF_B: begin
        nlen_next = rdata.len;
        if (endv == END_W'(rdata.start)) begin
          state_next = S_DF_M;
        end else begin
          i_next     = i + CNT_W'(1);
          state_next = S_DF_W;
        end
      end
      S_DF_M: begin
        areq.a           = TOT_W'(cur.len);
        areq.b           = TOT_W'(nlen);
        cur_next.len     = asum[LEN_W-1:0];
        i_next           = i + CNT_W'(2);
        pass_merged_next = 1'b1;
        state_next       = S_DF_W;
      end
      S_DF_W: begin
        we      = 1'b1;
        waddr   = wr[IDX_W-1:0];
        wdata   = cur;
        wr_next = wr + CNT_W'(1);
        if (i < cnt) begin
          state_next = S_DF_RA;
        end else begin
          cnt_next = wr_next;
          if (pass_merged && wr_next > CNT_W'(1)) begin
            chg_next         = 1'b1;
            i_next           = '0;
            wr_next          = '0;
            pass_merged_next = 1'b0;
            state_next       = S_DF_RA;
          end else begin
            chg_next   = chg | pass_merged;
            state_next = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      total <= total_next;
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    op          <= op_next;
    addr        <= addr_next;
    size        <= size_next;
    at          <= at_next;
    i           <= i_next;
    wr          <= wr_next;
    best        <= best_next;
    idx         <= idx_next;
    st          <= st_next;
    chg         <= chg_next;
    pass_merged <= pass_merged_next;
    cur         <= cur_next;
    nlen        <= nlen_next;
    if (state == S_DONE && (!out_valid || out_ready)) begin
      status      <= st;
      found_index <= idx;
      changed     <= chg;
      entry_count <= cnt;
      total_bytes <= total;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> out_valid)
    else $error("finished operation gave no result");

  a_compact: assert property (@(posedge clk) disable iff (rst)
    (state == S_DF_W) |-> (wr < i))
    else $error("merge write overtook read pointer");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CK) |-> (i < cnt))
    else $error("scan read past held entries");

endmodule
